// File: rtl/integer_set_table_assert.svh
// Assertion macros shared by the integer set table checker.
`ifndef INTEGER_SET_TABLE_ASSERT_SVH
`define INTEGER_SET_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define IST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define IST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ist_pkg.sv
// Shared types and constants of the integer set table.
`default_nettype none

package ist_pkg;

  // Default number of slots.
  localparam int CAPACITY_DEF = 16;

  // Slot index fields are sized for the largest supported table.
  localparam int IDX_MAX_W = 10;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_TEST   = 2'd2,
    OP_SPREAD = 2'd3
  } op_e;

  // Query item as it walks down the cell row.
  typedef struct packed {
    logic                  vld;
    op_e                   op;
    logic signed [31:0]    value;
    logic                  found;
    logic [IDX_MAX_W-1:0]  found_idx;
    logic                  has_free;
    logic [IDX_MAX_W-1:0]  free_idx;
    logic                  any;
    logic signed [31:0]    mx;
    logic signed [31:0]    mn;
  } tok_t;

  // Update broadcast to all cells when an item retires.
  typedef struct packed {
    logic                  set_en;
    logic                  clr_en;
    logic [IDX_MAX_W-1:0]  set_idx;
    logic [IDX_MAX_W-1:0]  clr_idx;
    logic signed [31:0]    value;
  } commit_t;

endpackage

`default_nettype wire

// File: rtl/ist_cell.sv
// One slot of the set: holds a member and updates the passing query item.
`default_nettype none

module ist_cell
  import ist_pkg::*;
#(
  parameter int IDX = 0
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    adv,
  input  wire tok_t    tok_in,
  input  wire commit_t commit,
  output      tok_t    tok_out
);

  localparam logic [IDX_MAX_W-1:0] MY_IDX = IDX_MAX_W'(IDX);

  logic               used_r;
  logic signed [31:0] value_r;
  tok_t               tok_r;
  tok_t               tok_nxt;

  // Fold this slot into the item: match, first free slot, running max and min.
  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.vld) begin
      if (used_r && (value_r == tok_in.value) && !tok_in.found) begin
        tok_nxt.found     = 1'b1;
        tok_nxt.found_idx = MY_IDX;
      end
      if (!used_r && !tok_in.has_free) begin
        tok_nxt.has_free = 1'b1;
        tok_nxt.free_idx = MY_IDX;
      end
      if (used_r) begin
        if (!tok_in.any) begin
          tok_nxt.any = 1'b1;
          tok_nxt.mx  = value_r;
          tok_nxt.mn  = value_r;
        end else begin
          if (value_r > tok_in.mx) tok_nxt.mx = value_r;
          if (value_r < tok_in.mn) tok_nxt.mn = value_r;
        end
      end
    end
  end

  // Advance the item to the neighbor.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else if (adv) begin
      tok_r <= tok_nxt;
    end
  end

  // Occupancy flag of the slot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
    end else if (commit.set_en && (commit.set_idx == MY_IDX)) begin
      used_r <= 1'b1;
    end else if (commit.clr_en && (commit.clr_idx == MY_IDX)) begin
      used_r <= 1'b0;
    end
  end

  // Stored member value.
  always_ff @(posedge clk) begin
    if (commit.set_en && (commit.set_idx == MY_IDX)) begin
      value_r <= commit.value;
    end
  end

  assign tok_out = tok_r;

endmodule

`default_nettype wire

// File: rtl/integer_set_table.sv
// Top level of the integer set table: launch, cell row and result register.
//
// A set of up to CAPACITY signed 32-bit members. Each item (insert, remove,
// membership test, or max minus min) enters a row of CAPACITY slot cells and
// moves one cell per clock while the row is not stalled, collecting the match,
// the first free slot and the running max and min. When it leaves the last cell
// the set is updated and the result is registered. One item is in flight at a
// time: a new item is accepted only after the previous one has left the row.
// A new item is accepted while the previous result still waits on the output;
// the row holds its item at the end until the output register frees up.
`default_nettype none

module integer_set_table
  import ist_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire logic [1:0]        in_op,
  input  wire logic signed [31:0] in_value,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      logic              out_ok,
  output      logic              out_full_res,
  output      logic [CNT_W-1:0]  out_count,
  output      logic              out_is_empty,
  output      logic [31:0]       out_spread
);

  tok_t             tok [0:CAPACITY];
  tok_t             head_r;
  tok_t             fin;
  commit_t          commit;
  logic             busy_r;
  logic             adv;
  logic             retire;
  logic             in_acc;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             ok_nxt;
  logic             full_nxt;
  logic [31:0]      spread_nxt;

  logic             out_valid_r;
  logic             ok_r;
  logic             full_r;
  logic [CNT_W-1:0] count_r;
  logic             empty_r;
  logic [31:0]      spread_r;

  assign in_ready = !busy_r;
  assign in_acc   = in_valid && !busy_r;
  assign fin      = tok[CAPACITY];
  assign adv      = !(fin.vld && out_valid_r && !out_ready);
  assign retire   = fin.vld && adv;

  // Launch the item into the row.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
    end else if (in_acc) begin
      head_r.vld       <= 1'b1;
      head_r.op        <= op_e'(in_op);
      head_r.value     <= in_value;
      head_r.found     <= 1'b0;
      head_r.found_idx <= '0;
      head_r.has_free  <= 1'b0;
      head_r.free_idx  <= '0;
      head_r.any       <= 1'b0;
      head_r.mx        <= '0;
      head_r.mn        <= '0;
    end else if (adv) begin
      head_r.vld <= 1'b0;
    end
  end

  assign tok[0] = head_r;

  // Row of slot cells.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ist_cell #(
      .IDX(i)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .tok_in (tok[i]),
      .commit (commit),
      .tok_out(tok[i+1])
    );
  end

  // Decide the outcome of the item leaving the row.
  always_comb begin
    commit         = '0;
    commit.set_idx = fin.free_idx;
    commit.clr_idx = fin.found_idx;
    commit.value   = fin.value;
    cnt_nxt        = cnt_r;
    ok_nxt         = 1'b0;
    full_nxt       = 1'b0;
    spread_nxt     = '0;
    unique case (fin.op)
      OP_INSERT: begin
        if (!fin.found) begin
          if (!fin.has_free) begin
            full_nxt = 1'b1;
          end else begin
            commit.set_en = retire;
            cnt_nxt       = cnt_r + 1'b1;
            ok_nxt        = 1'b1;
          end
        end
      end
      OP_REMOVE: begin
        if (fin.found) begin
          commit.clr_en = retire;
          cnt_nxt       = cnt_r - 1'b1;
          ok_nxt        = 1'b1;
        end
      end
      OP_TEST: begin
        ok_nxt = fin.found;
      end
      OP_SPREAD: begin
        if (fin.any) begin
          spread_nxt = $unsigned(fin.mx) - $unsigned(fin.mn);
          ok_nxt     = 1'b1;
        end
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase
  end

  // Track busy, member count and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        busy_r <= 1'b1;
      end else if (retire) begin
        busy_r <= 1'b0;
      end
      if (retire) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the result payload.
  always_ff @(posedge clk) begin
    if (retire) begin
      ok_r     <= ok_nxt;
      full_r   <= full_nxt;
      count_r  <= cnt_nxt;
      empty_r  <= (cnt_nxt == '0);
      spread_r <= spread_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_ok       = ok_r;
  assign out_full_res = full_r;
  assign out_count    = count_r;
  assign out_is_empty = empty_r;
  assign out_spread   = spread_r;

endmodule

`default_nettype wire

// File: rtl/ist_checker.sv
// Port-level checks of the integer set table and their bind.
`default_nettype none

`include "integer_set_table_assert.svh"

module ist_checker
  import ist_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               out_ok,
  input wire logic               out_full_res,
  input wire logic [CNT_W-1:0]   out_count,
  input wire logic               out_is_empty,
  input wire logic [31:0]        out_spread
);

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam int               OUT_W   = CNT_W + 35;

  logic             out_stall;
  logic [OUT_W-1:0] out_bits;
  logic             cnt_zero;
  logic             spread_nz;
  logic             spread_src;

  // Gather the result payload and the conditions the checks look at.
  assign out_stall  = out_valid && !out_ready;
  assign out_bits   = {out_ok, out_full_res, out_count, out_is_empty, out_spread};
  assign cnt_zero   = (out_count == '0);
  assign spread_nz  = out_valid && (out_spread != '0);
  assign spread_src = out_ok && !out_full_res && !out_is_empty;

  // A stalled result holds.
  `IST_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_bits), "stalled result changed")

  // Empty flag follows the member count.
  `IST_ASSERT_NOW(a_empty_cnt, out_valid, out_is_empty == cnt_zero, "empty flag and count disagree")

  // A refused insert never reports success.
  `IST_ASSERT_NOW(a_ok_full, out_valid, !(out_ok && out_full_res), "ok and full both set")

  // A nonzero spread comes only from a nonempty spread query.
  `IST_ASSERT_NOW(a_spread_ok, spread_nz, spread_src, "spread without members")

  // Count never exceeds the table size.
  `IST_ASSERT_NOW(a_cnt_max, out_valid, out_count <= CAP_CNT, "count beyond capacity")

endmodule

bind integer_set_table ist_checker #(.CAPACITY(CAPACITY)) u_ist_checker (.*);

`default_nettype wire
